/* rtl/hrce_pkg.sv */
// ----------------------------------------------------------------------------
// hrce_pkg: shared types and constants for the hex range cell enumerator
// Payload structs, controller/datapath command and status, step tables.
// ----------------------------------------------------------------------------
package hrce_pkg;

    localparam int COORD_IN_W = 6;   // offset column/row field width
    localparam int RANGE_W    = 3;   // ring_range field width
    localparam int GRID_W     = 7;   // grid size register width
    localparam int COORD_W    = 10;  // signed internal coordinate width
    localparam int DIR_W      = 3;   // walk direction index width

    localparam int DEF_MAX_RANGE = 4;
    localparam int DEF_MAX_DIM   = 64;

    localparam logic [GRID_W-1:0] GRID_RESET = GRID_W'(8);
    localparam logic [DIR_W-1:0]  DIR_LAST   = DIR_W'(5);

    // configuration register indexes
    localparam logic CFG_GRID_WIDTH  = 1'b0;
    localparam logic CFG_GRID_HEIGHT = 1'b1;

    typedef struct packed {
        logic [COORD_IN_W-1:0] center_col;
        logic [COORD_IN_W-1:0] center_row;
        logic [RANGE_W-1:0]    ring_range;
    } t_in;

    typedef struct packed {
        logic [COORD_IN_W-1:0] cell_col;
        logic [COORD_IN_W-1:0] cell_row;
        logic                  last_cell;
    } t_out;

    typedef struct packed {
        logic               load;      // take a new center
        logic               advance;   // step the walk along dir
        logic               restart;   // jump to the start of ring next_ring
        logic               push;      // move held cell out, hold the candidate
        logic               flush;     // move held cell out as the last one
        logic [DIR_W-1:0]   dir;
        logic [RANGE_W-1:0] next_ring;
    } t_cmd;

    typedef struct packed {
        logic in_grid;   // current candidate lies in the grid
        logic out_free;  // output register can take a cell this cycle
    } t_sts;

    function automatic logic signed [1:0] step_q(input logic [DIR_W-1:0] dir);
        logic signed [1:0] s;
        case (dir)
            3'd0:    s = 2'sd1;
            3'd1:    s = 2'sd0;
            3'd2:    s = -2'sd1;
            3'd3:    s = -2'sd1;
            3'd4:    s = 2'sd0;
            3'd5:    s = 2'sd1;
            default: s = 2'sd0;
        endcase
        return s;
    endfunction

    function automatic logic signed [1:0] step_r(input logic [DIR_W-1:0] dir);
        logic signed [1:0] s;
        case (dir)
            3'd0:    s = 2'sd0;
            3'd1:    s = 2'sd1;
            3'd2:    s = 2'sd1;
            3'd3:    s = 2'sd0;
            3'd4:    s = -2'sd1;
            3'd5:    s = -2'sd1;
            default: s = 2'sd0;
        endcase
        return s;
    endfunction

endpackage

/* rtl/hrce_ctrl.sv */
// ----------------------------------------------------------------------------
// hrce_ctrl: walk sequencer
// Tracks ring, direction and step counters and issues datapath commands.
// ----------------------------------------------------------------------------
module hrce_ctrl #(
    parameter int MAX_RANGE = hrce_pkg::DEF_MAX_RANGE
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic [hrce_pkg::RANGE_W-1:0] i_ring_range,
    output logic                         o_in_stall,
    input  hrce_pkg::t_sts               i_sts,
    output hrce_pkg::t_cmd               o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_WALK  = 3'b010,
        S_FLUSH = 3'b100
    } t_state;

    localparam logic [hrce_pkg::RANGE_W-1:0] RANGE_CAP = hrce_pkg::RANGE_W'(MAX_RANGE);

    t_state                       r_state, n_state;
    logic [hrce_pkg::RANGE_W-1:0] r_range, n_range;
    logic [hrce_pkg::RANGE_W-1:0] r_ring, n_ring;
    logic [hrce_pkg::RANGE_W-1:0] r_k, n_k;
    logic [hrce_pkg::DIR_W-1:0]   r_dir, n_dir;
    logic [hrce_pkg::RANGE_W-1:0] range_sat;
    logic                         accept, go, last_step;

    assign range_sat = (i_ring_range > RANGE_CAP) ? RANGE_CAP : i_ring_range;
    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);
    // a cell outside the grid never waits on the output
    assign go         = !i_sts.in_grid || i_sts.out_free;
    assign last_step  = (r_k == r_ring - hrce_pkg::RANGE_W'(1));

    always_comb begin
        n_state = r_state;
        n_range = r_range;
        n_ring  = r_ring;
        n_k     = r_k;
        n_dir   = r_dir;
        o_cmd           = '0;
        o_cmd.dir       = r_dir;
        o_cmd.next_ring = r_ring + hrce_pkg::RANGE_W'(1);
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    n_range    = range_sat;
                    n_ring     = hrce_pkg::RANGE_W'(1);
                    n_k        = '0;
                    n_dir      = '0;
                    n_state    = (range_sat == '0) ? S_FLUSH : S_WALK;
                end
            end
            S_WALK: begin
                if (go) begin
                    o_cmd.push = i_sts.in_grid;
                    if (last_step && r_dir == hrce_pkg::DIR_LAST) begin
                        if (r_ring == r_range) begin
                            n_state = S_FLUSH;
                        end else begin
                            o_cmd.restart = 1'b1;
                            n_ring        = r_ring + hrce_pkg::RANGE_W'(1);
                            n_k           = '0;
                            n_dir         = '0;
                        end
                    end else if (last_step) begin
                        o_cmd.advance = 1'b1;
                        n_k           = '0;
                        n_dir         = r_dir + hrce_pkg::DIR_W'(1);
                    end else begin
                        o_cmd.advance = 1'b1;
                        n_k           = r_k + hrce_pkg::RANGE_W'(1);
                    end
                end
            end
            S_FLUSH: begin
                if (i_sts.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_range <= '0;
            r_ring  <= '0;
            r_k     <= '0;
            r_dir   <= '0;
        end else begin
            r_state <= n_state;
            r_range <= n_range;
            r_ring  <= n_ring;
            r_k     <= n_k;
            r_dir   <= n_dir;
        end
    end

endmodule

/* rtl/hrce_dp.sv */
// ----------------------------------------------------------------------------
// hrce_dp: coordinate datapath
// Axial walk position, bounds check, held cell and output register.
// ----------------------------------------------------------------------------
module hrce_dp #(
    parameter int MAX_DIM = hrce_pkg::DEF_MAX_DIM
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [hrce_pkg::GRID_W-1:0] i_cfg_data,
    input  hrce_pkg::t_in               i_in_data,
    input  hrce_pkg::t_cmd              i_cmd,
    output hrce_pkg::t_sts              o_sts,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output hrce_pkg::t_out              o_out_data
);

    localparam int CW = hrce_pkg::COORD_W;
    localparam int GW = hrce_pkg::GRID_W;
    localparam int IW = hrce_pkg::COORD_IN_W;
    localparam logic [GW-1:0] DIM_CAP = GW'((MAX_DIM < 2**GW) ? MAX_DIM : 2**GW - 1);

    logic [GW-1:0]        r_grid_w, r_grid_h;
    logic signed [CW-1:0] r_cq, r_crow, r_q, r_r;
    logic [IW-1:0]        r_hold_col, r_hold_row;
    hrce_pkg::t_out       r_out;
    logic                 r_out_valid;

    logic signed [CW-1:0] in_col, in_row, in_cq, cand_col, dq, dr;
    logic signed [CW-1:0] w_ext, h_ext;
    logic [GW-1:0]        w_lim, h_lim;

    assign in_col = CW'(i_in_data.center_col);
    assign in_row = CW'(i_in_data.center_row);
    assign in_cq  = in_col - (in_row >>> 1);

    // floor(r/2) by arithmetic shift holds for negative rows
    assign cand_col = r_q + (r_r >>> 1);

    assign w_lim = (r_grid_w < DIM_CAP) ? r_grid_w : DIM_CAP;
    assign h_lim = (r_grid_h < DIM_CAP) ? r_grid_h : DIM_CAP;
    assign w_ext = CW'(w_lim);
    assign h_ext = CW'(h_lim);

    assign o_sts.in_grid  = (cand_col >= 0) && (cand_col < w_ext) &&
                            (r_r >= 0) && (r_r < h_ext);
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    assign dq = CW'(hrce_pkg::step_q(i_cmd.dir));
    assign dr = CW'(hrce_pkg::step_r(i_cmd.dir));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_w <= hrce_pkg::GRID_RESET;
            r_grid_h <= hrce_pkg::GRID_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == hrce_pkg::CFG_GRID_WIDTH) begin
                r_grid_w <= i_cfg_data;
            end else begin
                r_grid_h <= i_cfg_data;
            end
        end
    end

    // walk position and held cell
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cq       <= in_cq;
            r_crow     <= in_row;
            r_q        <= in_cq;
            r_r        <= in_row - CW'(1);
            r_hold_col <= i_in_data.center_col;
            r_hold_row <= i_in_data.center_row;
        end else begin
            if (i_cmd.advance) begin
                r_q <= r_q + dq;
                r_r <= r_r + dr;
            end else if (i_cmd.restart) begin
                r_q <= r_cq;
                r_r <= r_crow - CW'(i_cmd.next_ring);
            end
            if (i_cmd.push) begin
                r_hold_col <= cand_col[IW-1:0];
                r_hold_row <= r_r[IW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push || i_cmd.flush) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push || i_cmd.flush) begin
            r_out.cell_col  <= r_hold_col;
            r_out.cell_row  <= r_hold_row;
            r_out.last_cell <= i_cmd.flush;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* rtl/hex_range_cell_enumerator_unit.sv */
// ----------------------------------------------------------------------------
// hex_range_cell_enumerator_unit: hex spiral range enumerator
// Lists every odd-row offset hex cell within a range of a center, in spiral
// order, with the last listed cell flagged.
// ----------------------------------------------------------------------------
// A request carries a center cell (offset column and row) and a range; ranges
// above MAX_RANGE saturate. The unit returns the center first, always and
// without a bounds check, then rings 1 to range, each starting at axial
// (q, r - ring) and walking six directions, keeping only cells inside the
// configured grid (bounded by MAX_DIM). One candidate cell is tested per cycle
// by the walk sequencer, though one inside the grid waits while the output
// stalls. The input stalls from acceptance until the last cell is flushed.
// Each accepted cell is held one step so the final one can carry last_cell.
// Write grid_width (index 0) and grid_height (index 1) only while the unit
// is idle; both reset to 8.
module hex_range_cell_enumerator_unit #(
    parameter int MAX_RANGE = hrce_pkg::DEF_MAX_RANGE,
    parameter int MAX_DIM   = hrce_pkg::DEF_MAX_DIM
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration write port
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [hrce_pkg::GRID_W-1:0] i_cfg_data,
    // request channel
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  hrce_pkg::t_in               i_in_data,
    // cell channel
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output hrce_pkg::t_out              o_out_data
);

    hrce_pkg::t_cmd cmd;
    hrce_pkg::t_sts sts;

    // sequencer: ring/direction/step counters
    hrce_ctrl #(
        .MAX_RANGE (MAX_RANGE)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_ring_range (i_in_data.ring_range),
        .o_in_stall   (o_in_stall),
        .i_sts        (sts),
        .o_cmd        (cmd)
    );

    // datapath: coordinates, bounds check, held cell, output register
    hrce_dp #(
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking bench for hex_range_cell_enumerator_unit
// Drives center/range requests with random gaps, stalls the cell channel at
// random, predicts each spiral of cells in the bench and checks every cell in
// order. Walks through several grid sizes, the extremes among them.
// ----------------------------------------------------------------------------

class hex_cell_scoreboard;
    hrce_pkg::t_out cells_due[$];
    int             grid_cols;
    int             grid_rows;
    int             errors;
    int             step_q[6];
    int             step_r[6];

    function new();
        grid_cols = hrce_pkg::GRID_RESET;
        grid_rows = hrce_pkg::GRID_RESET;
        errors    = 0;
        step_q    = '{1, 0, -1, -1, 0, 1};
        step_r    = '{0, 1, 1, 0, -1, -1};
    endfunction

    function void set_grid(input logic [hrce_pkg::GRID_W-1:0] cols,
                           input logic [hrce_pkg::GRID_W-1:0] rows);
        grid_cols = cols;
        grid_rows = rows;
    endfunction

    // floor of v/2, also for negative rows
    function int half_down(input int v);
        return v >>> 1;
    endfunction

    function void note_request(input hrce_pkg::t_in req);
        hrce_pkg::t_out spiral[$];
        hrce_pkg::t_out spot;
        int col_lim;
        int row_lim;
        int reach;
        int axial_q;
        int q;
        int r;
        int col;
        col_lim = (grid_cols < hrce_pkg::DEF_MAX_DIM) ? grid_cols : hrce_pkg::DEF_MAX_DIM;
        row_lim = (grid_rows < hrce_pkg::DEF_MAX_DIM) ? grid_rows : hrce_pkg::DEF_MAX_DIM;
        reach   = req.ring_range;
        if (reach > hrce_pkg::DEF_MAX_RANGE) begin
            reach = hrce_pkg::DEF_MAX_RANGE;
        end
        axial_q = int'(req.center_col) - half_down(int'(req.center_row));
        // center goes out unconditionally
        spot.cell_col  = req.center_col;
        spot.cell_row  = req.center_row;
        spot.last_cell = 1'b0;
        spiral.push_back(spot);
        for (int ring = 1; ring <= reach; ring++) begin
            q = axial_q;
            r = int'(req.center_row) - ring;
            for (int dir = 0; dir < 6; dir++) begin
                for (int k = 0; k < ring; k++) begin
                    col = q + half_down(r);
                    if (col >= 0 && col < col_lim && r >= 0 && r < row_lim) begin
                        spot.cell_col = 6'(col);
                        spot.cell_row = 6'(r);
                        spiral.push_back(spot);
                    end
                    q += step_q[dir];
                    r += step_r[dir];
                end
            end
        end
        spot = spiral[spiral.size()-1];
        spot.last_cell = 1'b1;
        spiral[spiral.size()-1] = spot;
        foreach (spiral[i]) begin
            cells_due.push_back(spiral[i]);
        end
    endfunction

    function void check_cell(input hrce_pkg::t_out got);
        hrce_pkg::t_out want;
        if (cells_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected cell: expected none, got col=%0d row=%0d last=%0d",
                     $time, got.cell_col, got.cell_row, got.last_cell);
            return;
        end
        want = cells_due.pop_front();
        if (got.cell_col !== want.cell_col || got.cell_row !== want.cell_row ||
            got.last_cell !== want.last_cell) begin
            errors++;
            $display("%0t: cell mismatch: expected col=%0d row=%0d last=%0d,",
                     $time, want.cell_col, want.cell_row, want.last_cell);
            $display("    got col=%0d row=%0d last=%0d",
                     got.cell_col, got.cell_row, got.last_cell);
        end
    endfunction
endclass

module tb;

    localparam int IDLE_MAX       = 18;
    localparam int SETTLE_CYCLES  = 80;    // a full range-4 walk plus margin
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 4000;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_cfg_we;
    logic                        i_cfg_idx;
    logic [hrce_pkg::GRID_W-1:0] i_cfg_data;
    logic                        i_in_valid;
    logic                        o_in_stall;
    hrce_pkg::t_in               i_in_data;
    logic                        o_out_valid;
    logic                        i_out_stall;
    hrce_pkg::t_out              o_out_data;

    hex_cell_scoreboard sb;

    bit send_idle;
    bit recv_idle;
    int hold_cycles;
    int quiet_cycles;

    hex_range_cell_enumerator_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Report the verdict and stop; used by the normal end and the watchdog.
    task automatic close_run(input bit ok);
        if (ok) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    endtask

    // Sample both channels at the rising edge: note each accepted request,
    // check each accepted cell against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_stall === 1'b0) begin
            sb.note_request(i_in_data);
        end
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            sb.check_cell(o_out_data);
        end
    end

    // Watchdog: count cycles in which nothing moves on any port.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !i_out_stall) ||
            i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            close_run(1'b0);
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Cell receiver: draw a stall length per cell, fold in any long hold-off
    // requested by the stimulus, then wait for the next cell to be taken.
    initial begin
        int stall_len;
        i_out_stall = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            stall_len   = recv_idle ? $urandom_range(0, IDLE_MAX) : 0;
            stall_len  += hold_cycles;
            hold_cycles = 0;
            if (stall_len > 0) begin
                i_out_stall <= 1'b1;
                repeat (stall_len) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_out_valid === 1'b1 && !i_out_stall));
            @(negedge i_clk);
        end
    end

    // Offer one request after a drawn gap and hold it until taken. Call at a
    // falling edge; returns at the falling edge after acceptance with valid
    // still high, so a back-to-back request needs only one assignment.
    task automatic send_request(input hrce_pkg::t_in req);
        int gap;
        gap = send_idle ? $urandom_range(0, IDLE_MAX) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (!(i_in_valid && o_in_stall === 1'b0));
        @(negedge i_clk);
    endtask

    task automatic send_fields(input int col, input int row, input int reach);
        hrce_pkg::t_in req;
        req.center_col = 6'(col);
        req.center_row = 6'(row);
        req.ring_range = 3'(reach);
        send_request(req);
    endtask

    // Drop valid, wait for every predicted cell, then let the walk settle.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.cells_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Write both grid registers; call only while the unit is idle.
    task automatic write_grid(input logic [hrce_pkg::GRID_W-1:0] cols,
                              input logic [hrce_pkg::GRID_W-1:0] rows);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= hrce_pkg::CFG_GRID_WIDTH;
        i_cfg_data <= cols;
        @(negedge i_clk);
        i_cfg_idx  <= hrce_pkg::CFG_GRID_HEIGHT;
        i_cfg_data <= rows;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.set_grid(cols, rows);
    endtask

    // One grid setting with random requests. Most centers sit in or just
    // around the grid so rings get clipped at the edges; the rest land
    // anywhere in the field range. Optionally hold off the receiver for a
    // long stretch or pause the sender until the unit drains.
    task automatic random_phase(input int count,
                                input logic [hrce_pkg::GRID_W-1:0] cols,
                                input logic [hrce_pkg::GRID_W-1:0] rows,
                                input bit allow_idle, input bit long_hold,
                                input bit drain_pause);
        hrce_pkg::t_in req;
        int col_top;
        int row_top;
        wait_drained();
        write_grid(cols, rows);
        send_idle = allow_idle && ($urandom_range(0, 3) != 0);
        recv_idle = allow_idle && ($urandom_range(0, 3) != 0);
        col_top   = (cols < 62) ? cols + 1 : 63;
        row_top   = (rows < 62) ? rows + 1 : 63;
        for (int n = 0; n < count; n++) begin
            if (long_hold && n == count / 4) begin
                hold_cycles = LONG_HOLD;
            end
            if (drain_pause && n == count / 2) begin
                wait_drained();
            end
            if ($urandom_range(0, 3) != 0) begin
                req.center_col = 6'($urandom_range(0, col_top));
                req.center_row = 6'($urandom_range(0, row_top));
            end else begin
                req.center_col = 6'($urandom);
                req.center_row = 6'($urandom);
            end
            req.ring_range = 3'($urandom_range(0, 7));
            send_request(req);
        end
    endtask

    initial begin
        logic [hrce_pkg::GRID_W-1:0] rand_cols;
        logic [hrce_pkg::GRID_W-1:0] rand_rows;
        sb           = new();
        send_idle    = 1'b1;
        recv_idle    = 1'b1;
        hold_cycles  = 0;
        quiet_cycles = 0;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = hrce_pkg::CFG_GRID_WIDTH;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_in_data    = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset grid of 8 x 8: every range, saturating ranges, both row
        // parities, corners, centers outside the grid.
        send_fields(3, 3, 0);
        send_fields(3, 3, 1);
        send_fields(3, 4, 1);
        send_fields(3, 3, 2);
        send_fields(4, 4, 3);
        send_fields(3, 4, 4);
        send_fields(3, 3, 5);
        send_fields(3, 3, 7);
        send_fields(0, 0, 4);
        send_fields(7, 7, 4);
        send_fields(0, 7, 4);
        send_fields(7, 0, 4);
        send_fields(63, 63, 4);
        send_fields(20, 5, 1);

        // Empty grid: only centers come out.
        wait_drained();
        write_grid(7'd0, 7'd0);
        send_fields(0, 0, 4);
        send_fields(5, 5, 2);

        // Registers above the grid limit: bound clamps to the limit.
        wait_drained();
        write_grid(7'd127, 7'd127);
        send_fields(63, 63, 4);
        send_fields(0, 0, 4);
        send_fields(31, 32, 4);
        send_fields(62, 1, 6);

        // Single column, full height.
        wait_drained();
        write_grid(7'd1, 7'd64);
        send_fields(0, 63, 4);
        send_fields(0, 0, 2);

        rand_cols = 7'($urandom_range(0, 127));
        rand_rows = 7'($urandom_range(0, 127));
        random_phase(55, 7'd64, 7'd64, 1'b0, 1'b1, 1'b0);
        random_phase(55, 7'd5, 7'd9, 1'b1, 1'b0, 1'b1);
        random_phase(55, 7'd1, 7'd1, 1'b1, 1'b0, 1'b0);
        random_phase(55, 7'd127, 7'd3, 1'b1, 1'b0, 1'b0);
        random_phase(55, 7'd16, 7'd127, 1'b1, 1'b0, 1'b0);
        random_phase(55, rand_cols, rand_rows, 1'b1, 1'b1, 1'b0);
        rand_cols = 7'($urandom_range(1, 64));
        rand_rows = 7'($urandom_range(1, 64));
        random_phase(55, rand_cols, rand_rows, 1'b1, 1'b0, 1'b1);

        wait_drained();
        close_run(sb.errors == 0);
    end

endmodule
